### rtl/ibot_pkg.sv
// shared types, field widths and codes for the in-flight buffer overlap table
package ibot_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 48;
  localparam int MAX_RESULTS     = 16;

  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 48;
  localparam int END_W    = 49;
  localparam int CNT_W    = 32;
  localparam int BYTES_W  = 13;
  localparam int PROD_W   = (CNT_W - 1) + BYTES_W;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_CHECK   = 2'd0;
  localparam kind_t KIND_TRACK   = 2'd1;
  localparam kind_t KIND_RELEASE = 2'd2;
  localparam kind_t KIND_UNUSED  = 2'd3;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_IGNORED = 2'd1;
  localparam status_t ST_FULL    = 2'd2;

  typedef struct packed {
    kind_t                     kind;
    logic [ADDR_W-1:0]         start_address;
    logic signed [CNT_W-1:0]   element_count;
    logic [BYTES_W-1:0]        element_bytes;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]  entry_start;
    logic [END_W-1:0]   entry_end;
    status_t            status;
    logic               last;
  } out_item_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic shift;
    logic wr;
    logic wr_valid;
    logic check;
  } cell_ctl_t;

  // per-cell report flags that travel down the chain
  typedef struct packed {
    logic hit;
    logic free;
  } rep_flags_t;

endpackage

### rtl/ibot_stream_if.sv
// valid/ready stream channel carrying one payload per beat
interface ibot_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/ibot_cell.sv
// one table slot plus its stage of the report shift chain
module ibot_cell #(
  parameter int SW = 48,
  parameter int EW = 49,
  parameter int IW = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ibot_pkg::cell_ctl_t   ctl,
  input  logic [IW-1:0]         wr_idx,
  input  logic [IW-1:0]         own_idx,
  input  logic [SW-1:0]         q_start,
  input  logic [EW-1:0]         q_end,
  input  ibot_pkg::rep_flags_t  nb_flags,
  input  logic [IW-1:0]         nb_idx,
  input  logic [SW-1:0]         nb_start,
  input  logic [EW-1:0]         nb_end,
  output ibot_pkg::rep_flags_t  rep_flags,
  output logic [IW-1:0]         rep_idx,
  output logic [SW-1:0]         rep_start,
  output logic [EW-1:0]         rep_end
);

  logic          valid;
  logic [SW-1:0] slot_start;
  logic [EW-1:0] slot_end;
  logic          overlap;
  logic          same_start;
  logic          sel;
  ibot_pkg::rep_flags_t flags_now;

  assign sel        = ctl.wr && (wr_idx == own_idx);
  assign overlap    = valid && ({1'b0, q_start} < slot_end) && ({1'b0, slot_start} < q_end);
  assign same_start = valid && (slot_start == q_start);

  always_comb begin
    flags_now.hit  = ctl.check ? overlap : same_start;
    flags_now.free = !valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      rep_flags <= '0;
    end else begin
      if (sel) begin
        valid <= ctl.wr_valid;
      end
      if (ctl.load) begin
        rep_flags <= flags_now;
      end else if (ctl.shift) begin
        rep_flags <= nb_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && ctl.wr_valid) begin
      slot_start <= q_start;
      slot_end   <= q_end;
    end
    if (ctl.load) begin
      rep_idx   <= own_idx;
      rep_start <= slot_start;
      rep_end   <= slot_end;
    end else if (ctl.shift) begin
      rep_idx   <= nb_idx;
      rep_start <= nb_start;
      rep_end   <= nb_end;
    end
  end

endmodule

### rtl/ibot_ctrl.sv
// sequencer: item capture, range arithmetic, chain scan and result register
module ibot_ctrl #(
  parameter int TABLE_DEPTH = ibot_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_BITS   = ibot_pkg::ADDR_BITS_DEF,
  localparam int SW = (ADDR_BITS < ibot_pkg::ADDR_W) ? ADDR_BITS : ibot_pkg::ADDR_W,
  localparam int EW = SW + 1,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  ibot_stream_if.sink           req,
  ibot_stream_if.source         rsp,
  input  ibot_pkg::rep_flags_t  head_flags,
  input  logic [IW-1:0]         head_idx,
  input  logic [SW-1:0]         head_start,
  input  logic [EW-1:0]         head_end,
  input  logic [TABLE_DEPTH-1:0] hit_vec,
  input  logic [TABLE_DEPTH-1:0] free_vec,
  output ibot_pkg::cell_ctl_t   ctl,
  output logic [IW-1:0]         wr_idx,
  output logic [SW-1:0]         q_start,
  output logic [EW-1:0]         q_end
);

  localparam int CW = $clog2(ibot_pkg::MAX_RESULTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ADD  = 6'b000100,
    S_LOAD = 6'b001000,
    S_SCAN = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  ibot_pkg::kind_t               q_kind;
  logic [ibot_pkg::CNT_W-2:0]    q_cnt;
  logic [ibot_pkg::BYTES_W-1:0]  q_bytes;
  logic                          q_empty;
  logic [ibot_pkg::PROD_W-1:0]   prod;
  logic [CW-1:0]                 cnt;
  logic                          cnt_inc;
  logic                          out_valid;
  ibot_pkg::out_item_t           out_data;
  ibot_pkg::out_item_t           out_next;
  logic                          out_load;
  logic                          out_free;
  logic                          any_hit;
  logic                          any_free;
  logic                          rest_hit;
  logic                          ignore;
  logic                          accept;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  assign out_free = !out_valid || rsp.ready;
  assign any_hit  = |hit_vec;
  assign any_free = |free_vec;
  // a further hit behind the head of the chain
  assign rest_hit = |(hit_vec & ~TABLE_DEPTH'(1));
  assign ignore   = (q_kind == ibot_pkg::KIND_UNUSED) || (q_start == '0) ||
                    ((q_kind != ibot_pkg::KIND_RELEASE) && q_empty);

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.check    = (q_kind == ibot_pkg::KIND_CHECK);
    wr_idx       = head_idx;
    out_load     = 1'b0;
    cnt_inc      = 1'b0;
    out_next     = '0;
    out_next.status = ibot_pkg::ST_DONE;
    out_next.last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_MUL;
      end
      S_MUL:  state_next = S_ADD;
      S_ADD:  state_next = S_LOAD;
      S_LOAD: begin
        ctl.load   = 1'b1;
        state_next = ignore ? S_RESP : S_SCAN;
      end
      S_RESP: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_next.status = ibot_pkg::ST_IGNORED;
          state_next      = S_IDLE;
        end
      end
      S_SCAN: begin
        case (q_kind)
          ibot_pkg::KIND_CHECK: begin
            if (!any_hit) begin
              if (out_free) begin
                out_load   = 1'b1;
                state_next = S_IDLE;
              end
            end else if (head_flags.hit) begin
              if (out_free) begin
                out_load             = 1'b1;
                out_next.hit         = 1'b1;
                out_next.entry_index = ibot_pkg::INDEX_W'(head_idx);
                out_next.entry_start = ibot_pkg::ADDR_W'(head_start);
                out_next.entry_end   = ibot_pkg::END_W'(head_end);
                out_next.last        = (cnt == CW'(ibot_pkg::MAX_RESULTS - 1)) || !rest_hit;
                ctl.shift            = 1'b1;
                cnt_inc              = 1'b1;
                if (out_next.last) state_next = S_IDLE;
              end
            end else begin
              ctl.shift = 1'b1;
            end
          end
          ibot_pkg::KIND_TRACK: begin
            if (head_flags.hit || (head_flags.free && !any_hit)) begin
              if (out_free) begin
                out_load             = 1'b1;
                out_next.entry_index = ibot_pkg::INDEX_W'(head_idx);
                out_next.entry_start = ibot_pkg::ADDR_W'(q_start);
                out_next.entry_end   = ibot_pkg::END_W'(q_end);
                ctl.wr               = 1'b1;
                ctl.wr_valid         = 1'b1;
                state_next           = S_IDLE;
              end
            end else if (!any_hit && !any_free) begin
              if (out_free) begin
                out_load             = 1'b1;
                out_next.entry_start = ibot_pkg::ADDR_W'(q_start);
                out_next.entry_end   = ibot_pkg::END_W'(q_end);
                out_next.status      = ibot_pkg::ST_FULL;
                state_next           = S_IDLE;
              end
            end else begin
              ctl.shift = 1'b1;
            end
          end
          ibot_pkg::KIND_RELEASE: begin
            if (head_flags.hit) begin
              if (out_free) begin
                out_load             = 1'b1;
                out_next.entry_index = ibot_pkg::INDEX_W'(head_idx);
                out_next.entry_start = ibot_pkg::ADDR_W'(head_start);
                out_next.entry_end   = ibot_pkg::END_W'(head_end);
                ctl.wr               = 1'b1;
                state_next           = S_IDLE;
              end
            end else if (!any_hit) begin
              // unknown address: silent release
              if (out_free) begin
                out_load   = 1'b1;
                state_next = S_IDLE;
              end
            end else begin
              ctl.shift = 1'b1;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_kind  <= req.payload.kind;
      q_start <= SW'(req.payload.start_address);
      q_cnt   <= req.payload.element_count[ibot_pkg::CNT_W-2:0];
      q_empty <= (req.payload.element_count == '0) ||
                 req.payload.element_count[ibot_pkg::CNT_W-1];
      q_bytes <= (req.payload.element_bytes == '0) ? ibot_pkg::BYTES_W'(1)
                                                   : req.payload.element_bytes;
    end
    if (state == S_MUL) begin
      prod <= ibot_pkg::PROD_W'(q_cnt) * ibot_pkg::PROD_W'(q_bytes);
    end
    if (state == S_ADD) begin
      q_end <= EW'(ibot_pkg::END_W'(q_start) + ibot_pkg::END_W'(prod));
    end
    if (state == S_LOAD) begin
      cnt <= '0;
    end else if (cnt_inc) begin
      cnt <= cnt + CW'(1);
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

### rtl/inflight_buffer_overlap_table_core.sv
// in-flight buffer overlap table: sequencer and a row of slot cells
//
//   channel  dir  beat payload                                       handshake
//   req      in   kind, start_address, element_count, element_bytes  valid/ready
//   rsp      out  hit, entry_index, entry_start, entry_end, status,  valid/ready
//                 last
//
// an item passes through capture, multiply, add and cell compare, then the
// report chain shifts one slot per cycle toward the head, held only while
// the head waits to put a beat on a stalled rsp: track and release end on
// the slot they act on or once none qualifies, check at its last or 16th hit,
// one beat per hit; ignored items get one. req is taken only between items.
// synchronous reset clears the slot valid bits and the sequencer, no sweep.
module inflight_buffer_overlap_table_core #(
  parameter int TABLE_DEPTH = ibot_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_BITS   = ibot_pkg::ADDR_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ibot_stream_if.sink   req,
  ibot_stream_if.source rsp
);

  localparam int SW = (ADDR_BITS < ibot_pkg::ADDR_W) ? ADDR_BITS : ibot_pkg::ADDR_W;
  localparam int EW = SW + 1;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  ibot_pkg::cell_ctl_t   ctl;
  logic [IW-1:0]         wr_idx;
  logic [SW-1:0]         q_start;
  logic [EW-1:0]         q_end;
  ibot_pkg::rep_flags_t  rep_flags [TABLE_DEPTH];
  logic [IW-1:0]         rep_idx   [TABLE_DEPTH];
  logic [SW-1:0]         rep_start [TABLE_DEPTH];
  logic [EW-1:0]         rep_end   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] free_vec;

  ibot_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .head_flags (rep_flags[0]),
    .head_idx   (rep_idx[0]),
    .head_start (rep_start[0]),
    .head_end   (rep_end[0]),
    .hit_vec    (hit_vec),
    .free_vec   (free_vec),
    .ctl        (ctl),
    .wr_idx     (wr_idx),
    .q_start    (q_start),
    .q_end      (q_end)
  );

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ibot_pkg::rep_flags_t nb_flags;
    logic [IW-1:0]        nb_idx;
    logic [SW-1:0]        nb_start;
    logic [EW-1:0]        nb_end;

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign nb_flags = '0;
      assign nb_idx   = '0;
      assign nb_start = '0;
      assign nb_end   = '0;
    end else begin : g_link
      assign nb_flags = rep_flags[g+1];
      assign nb_idx   = rep_idx[g+1];
      assign nb_start = rep_start[g+1];
      assign nb_end   = rep_end[g+1];
    end

    assign hit_vec[g]  = rep_flags[g].hit;
    assign free_vec[g] = rep_flags[g].free;

    ibot_cell #(
      .SW (SW),
      .EW (EW),
      .IW (IW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_idx    (wr_idx),
      .own_idx   (IW'(g)),
      .q_start   (q_start),
      .q_end     (q_end),
      .nb_flags  (nb_flags),
      .nb_idx    (nb_idx),
      .nb_start  (nb_start),
      .nb_end    (nb_end),
      .rep_flags (rep_flags[g]),
      .rep_idx   (rep_idx[g]),
      .rep_start (rep_start[g]),
      .rep_end   (rep_end[g])
    );
  end

endmodule
